// File: hw/rtl/stq_pkg.sv
// shared types, constants and index helpers for the sorted timeout queue
package stq_pkg;

    // queue geometry
    localparam int DEPTH     = 16;
    localparam int MAX_OUT   = 16;
    localparam int IDX_W     = $clog2(DEPTH);
    localparam int CNT_W     = $clog2(DEPTH + 1);
    localparam int DRAIN_MAX = (MAX_OUT < DEPTH) ? MAX_OUT : DEPTH;

    // item kinds
    localparam logic KIND_ADD  = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    // input item
    typedef struct packed {
        logic               kind;
        logic [31:0]        owner_handle;
        logic signed [31:0] session_id;
        logic signed [31:0] delay_ms;
        logic [63:0]        now_ms;
    } cmd_t;

    // result item
    typedef struct packed {
        logic [31:0]        out_handle;
        logic signed [31:0] out_session;
        logic               dropped;
        logic               last;
    } result_t;

    // one stored event
    typedef struct packed {
        logic [63:0] expiry;
        logic [31:0] handle;
        logic [31:0] session;
    } entry_t;

    // write port of the entry store
    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
        entry_t           data;
    } mem_wr_t;

    // physical slot of a logical position counted from the head
    function automatic logic [IDX_W-1:0] wrap_idx(logic [IDX_W-1:0] base,
                                                  logic [CNT_W-1:0] off);
        logic [IDX_W:0] sum;
        sum = (IDX_W+1)'(base) + (IDX_W+1)'(off);
        if (sum >= (IDX_W+1)'(DEPTH))
        begin
            sum = sum - (IDX_W+1)'(DEPTH);
        end
        return sum[IDX_W-1:0];
    endfunction

endpackage

// File: hw/rtl/sorted_timeout_queue_unit.sv
// sorted timeout queue: sequencer around the entry store and shared comparator
//
//   channel   direction  signals                   handshake
//   command   in         cmd (cmd_t)               start high while busy low
//   result    out        result (result_t)         result_strobe, one cycle, no stall
//
// an add with a delay of zero or less, or one that finds the queue full, gives its
// item on the cycle after acceptance and the unit is free again at once.
// a stored add walks down from the tail, moving each later entry up one slot, then
// writes the new entry in the freed slot; one entry is handled per cycle.
// a tick on an empty queue only caches the time; otherwise it drains expired entries
// from the head, items earliest first, the final one on the first free cycle.
// reset empties the queue and clears the cached time; no clearing pass is needed.
// results cannot be held off: each item is shown on result for exactly one cycle.
module sorted_timeout_queue_unit
    import stq_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    output logic    busy,
    input  cmd_t    cmd,
    output logic    result_strobe,
    output result_t result
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_INS  = 4'b0010,
        S_PUT  = 4'b0100,
        S_DRN  = 4'b1000
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [IDX_W-1:0] head_reg, head_next;
    logic [CNT_W-1:0] pos_reg, pos_next;
    logic [63:0]      cached_reg, cached_next;
    entry_t           new_reg, new_next;
    entry_t           pend_reg, pend_next;
    logic             pend_valid_reg, pend_valid_next;
    result_t          result_reg, result_next;
    logic             strobe_reg, strobe_next;

    mem_wr_t          wr;
    logic [CNT_W-1:0] rd_pos;
    entry_t           rd_data;
    logic [63:0]      cmp_ref;
    logic             not_later;
    logic             accept;
    logic             delay_positive;
    logic             drain_hit;

    // entry store
    stq_mem u_mem (
        .clk     (clk),
        .wr      (wr),
        .rd_addr (wrap_idx(head_reg, rd_pos)),
        .rd_data (rd_data)
    );

    // shared comparator: new expiry while inserting, cached time while draining
    assign cmp_ref = (state_reg == S_INS) ? new_reg.expiry : cached_reg;

    stq_cmp u_cmp (
        .expiry    (rd_data.expiry),
        .ref_time  (cmp_ref),
        .not_later (not_later)
    );

    assign busy          = (state_reg != S_IDLE);
    assign accept        = start && (state_reg == S_IDLE);
    assign delay_positive = !cmd.delay_ms[31] && (cmd.delay_ms != 32'sd0);
    assign drain_hit     = (pos_reg < count_reg) && (pos_reg < CNT_W'(DRAIN_MAX))
                           && not_later;

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        head_next       = head_reg;
        pos_next        = pos_reg;
        cached_next     = cached_reg;
        new_next        = new_reg;
        pend_next       = pend_reg;
        pend_valid_next = pend_valid_reg;
        result_next     = result_reg;
        strobe_next     = 1'b0;
        wr.en           = 1'b0;
        wr.addr         = wrap_idx(head_reg, pos_reg);
        wr.data         = new_reg;
        rd_pos          = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (cmd.kind == KIND_ADD)
                    begin
                        if (!delay_positive || (count_reg == CNT_W'(DEPTH)))
                        begin
                            // immediate fire or refused add
                            result_next.out_handle  = cmd.owner_handle;
                            result_next.out_session = cmd.session_id;
                            result_next.dropped     = delay_positive;
                            result_next.last        = 1'b1;
                            strobe_next             = 1'b1;
                        end
                        else
                        begin
                            new_next.expiry  = cached_reg + {32'd0, cmd.delay_ms};
                            new_next.handle  = cmd.owner_handle;
                            new_next.session = cmd.session_id;
                            if (count_reg == '0)
                            begin
                                pos_next   = '0;
                                state_next = S_PUT;
                            end
                            else
                            begin
                                pos_next   = count_reg - CNT_W'(1);
                                rd_pos     = count_reg - CNT_W'(1);
                                state_next = S_INS;
                            end
                        end
                    end
                    else
                    begin
                        cached_next = cmd.now_ms;
                        if (count_reg != '0)
                        begin
                            pos_next        = '0;
                            rd_pos          = '0;
                            pend_valid_next = 1'b0;
                            state_next      = S_DRN;
                        end
                    end
                end
            end

            // walk down from the tail, moving later entries up one slot
            S_INS:
            begin
                if (not_later)
                begin
                    pos_next   = pos_reg + CNT_W'(1);
                    state_next = S_PUT;
                end
                else
                begin
                    wr.en   = 1'b1;
                    wr.addr = wrap_idx(head_reg, pos_reg + CNT_W'(1));
                    wr.data = rd_data;
                    if (pos_reg == '0)
                    begin
                        state_next = S_PUT;
                    end
                    else
                    begin
                        pos_next = pos_reg - CNT_W'(1);
                        rd_pos   = pos_reg - CNT_W'(1);
                    end
                end
            end

            // place the new entry in the freed slot
            S_PUT:
            begin
                wr.en      = 1'b1;
                count_next = count_reg + CNT_W'(1);
                state_next = S_IDLE;
            end

            // hold one expired entry back so that the final one can be marked
            S_DRN:
            begin
                if (pend_valid_reg)
                begin
                    result_next.out_handle  = pend_reg.handle;
                    result_next.out_session = pend_reg.session;
                    result_next.dropped     = 1'b0;
                    result_next.last        = !drain_hit;
                    strobe_next             = 1'b1;
                end
                if (drain_hit)
                begin
                    pend_next       = rd_data;
                    pend_valid_next = 1'b1;
                    pos_next        = pos_reg + CNT_W'(1);
                    rd_pos          = pos_reg + CNT_W'(1);
                end
                else
                begin
                    head_next       = wrap_idx(head_reg, pos_reg);
                    count_next      = count_reg - pos_reg;
                    pend_valid_next = 1'b0;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            head_reg       <= '0;
            pos_reg        <= '0;
            cached_reg     <= '0;
            pend_valid_reg <= 1'b0;
            strobe_reg     <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            head_reg       <= head_next;
            pos_reg        <= pos_next;
            cached_reg     <= cached_next;
            pend_valid_reg <= pend_valid_next;
            strobe_reg     <= strobe_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        new_reg    <= new_next;
        pend_reg   <= pend_next;
        result_reg <= result_next;
    end

    assign result_strobe = strobe_reg;
    assign result        = result_reg;

    // fill level never passes the store size
    assert property (@(posedge clk) disable iff (!rst_n) count_reg <= CNT_W'(DEPTH))
        else $error("entry count above depth");

    // an item only follows an accepted command or a drain step
    assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe |-> ($past(accept) || $past(state_reg == S_DRN)))
        else $error("result item without cause");

    // a refused add only happens with the queue full
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_strobe && result.dropped) |-> (count_reg == CNT_W'(DEPTH)))
        else $error("add dropped while queue had room");

    // shifting entries leaves the fill level alone
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_INS) |=> $stable(count_reg))
        else $error("entry count changed during insertion");

    // one-hot state register
    assert property (@(posedge clk) disable iff (!rst_n) $onehot(state_reg))
        else $error("state register not one-hot");

endmodule

// File: hw/rtl/stq_mem.sv
// entry store: one write port, one registered read port
module stq_mem
    import stq_pkg::*;
(
    input  logic             clk,
    input  mem_wr_t          wr,
    input  logic [IDX_W-1:0] rd_addr,
    output entry_t           rd_data
);

    entry_t mem [DEPTH];
    entry_t rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// File: hw/rtl/stq_cmp.sv
// shared expiry comparator: is the stored expiry at or before the reference time
module stq_cmp
    import stq_pkg::*;
(
    input  logic [63:0] expiry,
    input  logic [63:0] ref_time,
    output logic        not_later
);

    // unsigned 64-bit compare
    assign not_later = (expiry <= ref_time);

endmodule
